[design/box_blur_row_assert.svh]
// assertion macros used by the checker file
`ifndef BOX_BLUR_ROW_ASSERT_SVH
`define BOX_BLUR_ROW_ASSERT_SVH

// condition implies consequence in the same cycle
`define BBR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition implies consequence in the next cycle
`define BBR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/bbr_pkg.sv]
package bbr_pkg;

    localparam int RADIUS_W       = 5;
    localparam int RADIUS_MAX_DEF = 31;
    localparam int RADIUS_RESET   = 1;
    localparam int PIX_W          = 8;
    localparam int CH_N           = 3;
    localparam int N_W            = RADIUS_W + 1;
    localparam int SUM_W          = 14;
    localparam int X_W            = SUM_W + 1;
    localparam int RECIP_K        = 22;
    localparam int RECIP_W        = 22;
    localparam int PROD_W         = X_W + RECIP_W;
    localparam int LEVELS         = 1 << RADIUS_W;

    typedef logic [PIX_W-1:0] t_pix;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_ADV,
        S_MUL,
        S_EMIT
    } t_state;

endpackage

[design/box_blur_row.sv]
// Row pass of a box filter with clamp-to-edge over a stream of blue, green and red
// pixels. Each output is the round-half-up average of the 2r+1 pixels centered on it,
// where pixels beyond either end of the row read as the first or last pixel. An output
// appears once pixel j+r has been taken; the pixel marked row_end makes r more window
// steps that flush the outputs still pending, the last one flagged row_done, so a row
// yields one output per pixel. Each pixel goes through a history read and a sum update, then
// a reciprocal multiply and an output load if it yields an output, and each flush step of a
// row end does the same; a stalled output holds the output load for as long as the stall
// lasts. The input stays stalled until the pixel and its flush steps are done. This order
// is set by the one-read-per-step sequencer around the pixel history ring memory. Writing
// the radius restarts the current row.
module box_blur_row #(
    parameter int RADIUS_MAX = bbr_pkg::RADIUS_MAX_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [bbr_pkg::RADIUS_W-1:0] i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [bbr_pkg::PIX_W-1:0]    i_blue_in,
    input  logic [bbr_pkg::PIX_W-1:0]    i_green_in,
    input  logic [bbr_pkg::PIX_W-1:0]    i_red_in,
    input  logic                         i_row_end,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [bbr_pkg::PIX_W-1:0]    o_blue_out,
    output logic [bbr_pkg::PIX_W-1:0]    o_green_out,
    output logic [bbr_pkg::PIX_W-1:0]    o_red_out,
    output logic                         o_row_done
);

    import bbr_pkg::*;

    localparam int HIST_N = 2 * RADIUS_MAX + 1;
    localparam int AW     = $clog2(HIST_N + 1);
    localparam int DEPTH  = 1 << AW;
    localparam int MV_W   = AW + 1;
    localparam int HI_W   = PROD_W - RECIP_K - PIX_W;

    t_state               r_state, n_state;
    logic [RADIUS_W-1:0]  r_radius;
    logic [AW-1:0]        r_pos;
    logic [AW-1:0]        r_wp;
    logic [AW-1:0]        r_raddr;
    t_pix                 r_px    [CH_N];
    t_pix                 r_first [CH_N];
    logic [SUM_W-1:0]     r_sum   [CH_N];
    logic [PROD_W-1:0]    r_prod  [CH_N];
    logic                 r_last;
    logic [MV_W-1:0]      r_mv;
    logic [RADIUS_W-1:0]  r_step;
    logic [RECIP_W-1:0]   r_recip;
    logic [RECIP_W-1:0]   recip_tab [LEVELS];
    logic                 r_ovalid;
    t_pix                 r_oval  [CH_N];
    logic                 r_odone;

    logic [N_W-1:0]       n_win;
    logic [RADIUS_W-1:0]  cfg_radius;
    logic                 cfg_acc;
    logic                 in_acc;
    logic                 out_free;
    logic                 emit_now;
    logic                 more;
    logic                 leave_first;
    logic                 do_emit;
    logic [AW-1:0]        ram_raddr;
    logic [CH_N*PIX_W-1:0] ram_wdata;
    logic [CH_N*PIX_W-1:0] ram_rdata;

    for (genvar g = 0; g < LEVELS; g++) begin : g_recip
        localparam int unsigned DIVISOR = 2 * (2 * g + 1);
        localparam int unsigned RECIP   = ((1 << RECIP_K) + DIVISOR - 1) / DIVISOR;
        assign recip_tab[g] = RECIP_W'(RECIP);
    end

    assign n_win       = {r_radius, 1'b1};
    assign cfg_radius  = (int'(i_cfg_data) > RADIUS_MAX) ? RADIUS_W'(RADIUS_MAX)
                                                         : i_cfg_data;
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_in_stall  = (r_state != S_IDLE) || i_cfg_valid;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_free    = !r_ovalid || !i_out_stall;
    assign more        = r_last && (r_step != r_radius);
    assign leave_first = r_mv < MV_W'(n_win);
    assign do_emit     = r_mv >= MV_W'(r_radius);
    assign ram_wdata   = {i_red_in, i_green_in, i_blue_in};

    always_comb begin
        n_state   = r_state;
        emit_now  = 1'b0;
        ram_raddr = r_wp - AW'(n_win);
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_ADV;
                end
            end
            S_READ: begin
                ram_raddr = r_raddr;
                n_state   = S_ADV;
            end
            S_ADV: begin
                if (do_emit) begin
                    n_state = S_MUL;
                end else if (more) begin
                    n_state = S_READ;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_MUL: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    emit_now = 1'b1;
                    n_state  = more ? S_READ : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    bbr_ram #(
        .WIDTH (CH_N * PIX_W),
        .DEPTH (DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (in_acc),
        .i_waddr (r_wp),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_W'(RADIUS_RESET);
            r_pos    <= '0;
            r_wp     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (cfg_acc) begin
                r_radius <= cfg_radius;
                r_pos    <= '0;
            end else if (in_acc) begin
                r_wp <= r_wp + AW'(1);
                if (i_row_end) begin
                    r_pos <= '0;
                end else if (r_pos != AW'(HIST_N)) begin
                    r_pos <= r_pos + AW'(1);
                end
            end
            if (emit_now) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_recip <= recip_tab[r_radius];
        if (in_acc) begin
            r_px[0] <= i_blue_in;
            r_px[1] <= i_green_in;
            r_px[2] <= i_red_in;
            r_last  <= i_row_end;
            r_mv    <= MV_W'(r_pos);
            r_step  <= '0;
            r_raddr <= r_wp - AW'(n_win) + AW'(1);
        end
        if (r_state == S_READ) begin
            r_mv    <= r_mv + MV_W'(1);
            r_step  <= r_step + RADIUS_W'(1);
            r_raddr <= r_raddr + AW'(1);
        end
        for (int c = 0; c < CH_N; c++) begin
            if (cfg_acc) begin
                r_sum[c] <= '0;
            end else if (r_state == S_ADV) begin
                if (r_mv == '0) begin
                    r_first[c] <= r_px[c];
                    r_sum[c]   <= SUM_W'(n_win) * SUM_W'(r_px[c]);
                end else if (leave_first) begin
                    r_sum[c] <= r_sum[c] + SUM_W'(r_px[c]) - SUM_W'(r_first[c]);
                end else begin
                    r_sum[c] <= r_sum[c] + SUM_W'(r_px[c])
                                - SUM_W'(ram_rdata[c*PIX_W +: PIX_W]);
                end
            end
            if (r_state == S_MUL) begin
                r_prod[c] <= PROD_W'({r_sum[c], 1'b0} + X_W'(n_win)) * PROD_W'(r_recip);
            end
            if (emit_now) begin
                if (r_prod[c][PROD_W-1 -: HI_W] != '0) begin
                    r_oval[c] <= '1;
                end else begin
                    r_oval[c] <= r_prod[c][RECIP_K +: PIX_W];
                end
            end
        end
        if (emit_now) begin
            r_odone <= r_last && (r_step == r_radius);
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_blue_out  = r_oval[0];
    assign o_green_out = r_oval[1];
    assign o_red_out   = r_oval[2];
    assign o_row_done  = r_odone;

endmodule

[design/bbr_ram.sv]
module bbr_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/box_blur_row_chk.sv]
`include "box_blur_row_assert.svh"

module box_blur_row_chk (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_cfg_valid,
    input logic                         o_cfg_ready,
    input logic                         i_in_valid,
    input logic                         o_in_stall,
    input logic                         o_out_valid,
    input logic                         i_out_stall,
    input logic [bbr_pkg::PIX_W-1:0]    o_blue_out,
    input logic [bbr_pkg::PIX_W-1:0]    o_green_out,
    input logic [bbr_pkg::PIX_W-1:0]    o_red_out,
    input logic                         o_row_done
);

    // stalled result holds
    `BBR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_blue_out) && $stable(o_green_out) &&
        $stable(o_red_out) && $stable(o_row_done), "stalled output changed")

    // one pixel at a time
    `BBR_ASSERT_NEXT(a_in_busy, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall,
        "pixel taken while busy")

    // radius write leaves block idle
    `BBR_ASSERT_NEXT(a_cfg_idle, i_clk, i_rst_n, i_cfg_valid && o_cfg_ready, o_cfg_ready,
        "not idle after config transfer")

    // no result right after reset
    `BBR_ASSERT_SAME(a_rst_out, i_clk, i_rst_n, $past(!i_rst_n), !o_out_valid,
        "output valid after reset")

endmodule

bind box_blur_row box_blur_row_chk u_chk (.*);

[verif/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
    import bbr_pkg::*;

    localparam int HIST_N        = 2 * RADIUS_MAX_DEF + 1;
    localparam int POS_LIMIT     = 2 * RADIUS_MAX_DEF + 1;
    localparam int SETTLE_CYCLES = 4 * RADIUS_MAX_DEF + 16;
    localparam int IDLE_PCT      = 37;

    // index 0 blue, 1 green, 2 red
    typedef logic [CH_N-1:0][PIX_W-1:0] t_rgb;

    typedef struct packed {
        t_pix blue;
        t_pix green;
        t_pix red;
        logic row_done;
    } t_blur_px;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_cfg_valid = 1'b0;
    logic [RADIUS_W-1:0] i_cfg_data  = '0;
    logic                i_in_valid  = 1'b0;
    logic [PIX_W-1:0]    i_blue_in   = '0;
    logic [PIX_W-1:0]    i_green_in  = '0;
    logic [PIX_W-1:0]    i_red_in    = '0;
    logic                i_row_end   = 1'b0;
    logic                i_out_stall = 1'b0;
    logic                o_cfg_ready;
    logic                o_in_stall;
    logic                o_out_valid;
    logic [PIX_W-1:0]    o_blue_out;
    logic [PIX_W-1:0]    o_green_out;
    logic [PIX_W-1:0]    o_red_out;
    logic                o_row_done;

    box_blur_row dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_blue_in   (i_blue_in),
        .i_green_in  (i_green_in),
        .i_red_in    (i_red_in),
        .i_row_end   (i_row_end),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_blue_out  (o_blue_out),
        .o_green_out (o_green_out),
        .o_red_out   (o_red_out),
        .o_row_done  (o_row_done)
    );

    always #10 i_clk = ~i_clk;

    // predictor state
    t_rgb                win_hist [HIST_N];
    logic [SUM_W-1:0]    win_sum  [CH_N];
    t_rgb                row_first;
    int unsigned         row_pos;
    logic [RADIUS_W-1:0] blur_radius;

    t_blur_px blurred_q [$];
    t_blur_px seen_px;
    t_blur_px want_px;
    int       mismatch_cnt = 0;
    bit       quiet        = 1'b0;

    function automatic void clear_window();
        row_pos = 0;
        for (int c = 0; c < CH_N; c++) win_sum[c] = '0;
    endfunction

    function automatic void slide_in(input t_rgb px, input int unsigned pos);
        int unsigned span;
        span = 2 * blur_radius + 1;
        for (int c = 0; c < CH_N; c++) begin
            if (pos == 0) begin
                row_first[c] = px[c];
                win_sum[c]   = SUM_W'(span * px[c]);
            end else begin
                win_sum[c] = win_sum[c] + px[c]
                           - ((pos < span) ? row_first[c] : win_hist[2 * blur_radius][c]);
            end
        end
        for (int k = HIST_N - 1; k > 0; k--) win_hist[k] = win_hist[k-1];
        win_hist[0] = px;
    endfunction

    function automatic t_pix window_avg(input logic [SUM_W-1:0] s);
        int unsigned n;
        int unsigned q;
        n = 2 * blur_radius + 1;
        q = (2 * s + n) / (2 * n);
        return (q > 255) ? 8'd255 : q[PIX_W-1:0];
    endfunction

    function automatic void push_avg(input logic done);
        t_blur_px v;
        v.blue     = window_avg(win_sum[0]);
        v.green    = window_avg(win_sum[1]);
        v.red      = window_avg(win_sum[2]);
        v.row_done = done;
        blurred_q.push_back(v);
    endfunction

    function automatic void predict_blur(input t_rgb px, input logic last);
        int unsigned m;
        int unsigned r;
        m = row_pos;
        r = 32'(blur_radius);
        slide_in(px, m);
        if (m >= r) push_avg(last && r == 0);
        if (last) begin
            for (int unsigned i = 1; i <= r; i++) begin
                slide_in(px, m + i);
                if (m + i >= r) push_avg(i == r);
            end
            row_pos = 0;
        end else begin
            row_pos = (m + 1 > POS_LIMIT) ? POS_LIMIT : m + 1;
        end
    endfunction

    task automatic report_mismatch(input string what, input t_blur_px want,
                                   input t_blur_px got);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
            $display("%0t: %s: expected b=%0d g=%0d r=%0d done=%0b, %s",
                     $time, what, want.blue, want.green, want.red, want.row_done,
                     $sformatf("got b=%0d g=%0d r=%0d done=%0b",
                               got.blue, got.green, got.red, got.row_done));
    endtask

    // output side: check each transfer, stall at random unless quiet
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            seen_px = {o_blue_out, o_green_out, o_red_out, o_row_done};
            if (blurred_q.size() == 0) begin
                report_mismatch("unexpected output", '0, seen_px);
            end else begin
                want_px = blurred_q.pop_front();
                if (seen_px.blue !== want_px.blue || seen_px.green !== want_px.green ||
                    seen_px.red !== want_px.red || seen_px.row_done !== want_px.row_done)
                    report_mismatch("output mismatch", want_px, seen_px);
            end
        end
        i_out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
    end

    task automatic send_pixel(input t_rgb px, input logic last);
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            i_blue_in  <= PIX_W'($urandom_range(255));
            i_green_in <= PIX_W'($urandom_range(255));
            i_red_in   <= PIX_W'($urandom_range(255));
            i_row_end  <= 1'($urandom_range(1));
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_blue_in  <= px[0];
        i_green_in <= px[1];
        i_red_in   <= px[2];
        i_row_end  <= last;
        do @(posedge i_clk); while (o_in_stall);
        predict_blur(px, last);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (blurred_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_radius(input logic [RADIUS_W-1:0] r);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= r;
        do @(posedge i_clk); while (!o_cfg_ready);
        blur_radius = r;
        clear_window();
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_rgb rand_px();
        return {8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255))};
    endfunction

    task automatic send_row(input int len);
        for (int k = 0; k < len; k++) send_pixel(rand_px(), k == len - 1);
    endtask

    // reset radius, extremes, single, two and three pixel rows
    task automatic test_reset_radius();
        send_pixel({8'd255, 8'd0, 8'd170}, 1'b1);
        send_pixel({8'd0, 8'd0, 8'd0}, 1'b0);
        send_pixel({8'd255, 8'd255, 8'd255}, 1'b0);
        send_pixel({8'd85, 8'd170, 8'd1}, 1'b1);
        send_pixel({8'd255, 8'd255, 8'd255}, 1'b0);
        send_pixel({8'd0, 8'd128, 8'd0}, 1'b1);
    endtask

    // window of one pixel passes the input through
    task automatic test_radius_zero();
        write_radius(5'd0);
        send_pixel({8'd0, 8'd255, 8'd127}, 1'b0);
        send_pixel({8'd255, 8'd0, 8'd128}, 1'b0);
        send_pixel({8'd17, 8'd34, 8'd51}, 1'b1);
    endtask

    // rows shorter than r+1 only produce on their last pixel
    task automatic test_short_rows();
        write_radius(5'd3);
        send_row(1);
        send_row(2);
        send_row(3);
    endtask

    // radius write in the middle of a row restarts it
    task automatic test_restart();
        write_radius(5'd2);
        send_row(3);
        send_pixel(rand_px(), 1'b0);
        write_radius(5'd1);
        send_row(2);
    endtask

    task automatic test_max_radius();
        write_radius(5'd31);
        send_pixel({8'd255, 8'd255, 8'd255}, 1'b0);
        send_pixel({8'd255, 8'd255, 8'd255}, 1'b0);
        send_pixel({8'd0, 8'd0, 8'd0}, 1'b1);
    endtask

    // long row at full radius: history wraps and row position saturates
    task automatic test_long_row();
        write_radius(5'd31);
        send_row(70);
    endtask

    task automatic test_random_rows(input int n_pix, input logic [RADIUS_W-1:0] r,
                                    input bit open_tail);
        int sent;
        int len;
        int span;
        sent = 0;
        span = 2 * r + 1;
        write_radius(r);
        while (sent < n_pix) begin
            if ($urandom_range(7) == 0) len = $urandom_range(span + 8, span);
            else len = $urandom_range(r + 3, 1);
            if (len > n_pix - sent) len = n_pix - sent;
            for (int k = 0; k < len; k++)
                send_pixel(rand_px(), k == len - 1 && !(open_tail && sent + len >= n_pix));
            sent += len;
        end
    endtask

    initial begin
        blur_radius = RADIUS_W'(RADIUS_RESET);
        row_first   = '0;
        for (int k = 0; k < HIST_N; k++) win_hist[k] = '0;
        clear_window();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_radius();
        test_radius_zero();
        test_short_rows();
        test_restart();
        test_max_radius();
        quiet = 1'b1;
        test_long_row();
        test_random_rows(12, RADIUS_W'($urandom_range(30, 1)), 1'b0);
        quiet = 1'b0;
        test_random_rows(12, 5'd2, 1'b1);
        test_random_rows(8, 5'd0, 1'b0);
        test_random_rows(12, 5'd7, 1'b1);
        test_random_rows(10, 5'd31, 1'b0);
        test_random_rows(10, 5'd1, 1'b0);
        test_random_rows(10, RADIUS_W'($urandom_range(31)), 1'b0);

        wait_drained();
        if (mismatch_cnt == 0 && blurred_q.size() == 0) begin
            $display("box_blur_row test passed");
        end else begin
            $display("box_blur_row test failed");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("box_blur_row test failed");
        $finish;
    end

endmodule
